// File: hw/rtl/pooled_block_bitmap_allocator_unit_macros.svh
// assertion helpers, sampled on clk_i and off while rst_ni is low
`ifndef POOLED_BLOCK_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define POOLED_BLOCK_BITMAP_ALLOCATOR_UNIT_MACROS_SVH

// plain property
`define PBBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define PBBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pbba_pkg.sv
`default_nettype none

package pbba_pkg;

  localparam int MaxPools      = 8;
  localparam int BlocksPerPool = 32;
  localparam int SlotW         = 3;
  localparam int BlkW          = 5;
  localparam int NBlkW         = 6;
  localparam int CountW        = 4;
  localparam int BsW           = 13;
  localparam int OffW          = 17;
  localparam int MaxBlockSize  = 4096;
  localparam int CfgIdxW       = 1;
  localparam int CfgDataW      = 13;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_SPACE    = 2'd1,
    ST_NOT_IN_ZONE = 2'd2,
    ST_DOUBLE_FREE = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BLOCKS_PER_POOL = 1'b0,
    REG_BLOCK_SIZE      = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [0:0]      operation;
    logic [SlotW-1:0] free_pool;
    logic [BlkW-1:0]  free_block;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [SlotW-1:0] granted_pool;
    logic [BlkW-1:0]  granted_block;
    logic [OffW-1:0]  byte_offset;
    logic             pool_opened;
    logic             pool_released;
  } rsp_t;

  // contents of one list position, shifted toward the head on release
  typedef struct packed {
    logic                     valid;
    logic [SlotW-1:0]         slot;
    logic [NBlkW-1:0]         blocks;
    logic [BlocksPerPool-1:0] map;
  } cell_data_t;

  // broadcast to every cell
  typedef struct packed {
    logic             free_en;
    logic [SlotW-1:0] free_pool;
    logic [BlkW-1:0]  free_block;
    logic [SlotW-1:0] open_slot;
    logic [NBlkW-1:0] open_blocks;
  } cell_cmd_t;

  // per cell report, fields zero unless the cell is the one concerned
  typedef struct packed {
    logic             tok;
    logic             hit;
    logic             miss;
    logic [SlotW-1:0] grant_slot;
    logic [BlkW-1:0]  grant_blk;
    logic             zone_ok;
    logic             bit_set;
    logic             released;
  } cell_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/pooled_block_bitmap_allocator_unit.sv
// alloc: the search token steps one list cell per cycle over up to 8 cells and a pool opens
//   on the miss cycle, then the result is registered and loaded with its byte offset in S_FIN
// free: the request is checked against the pools in S_FREE, then its result loads in S_FIN
// one request in flight: a new request is taken only in S_IDLE
// the next request is taken while a result waits on a stalled output
// reset (async, active low) empties every pool and sets blocks_per_pool 32, block_size 16
`default_nettype none

module pooled_block_bitmap_allocator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pbba_pkg::req_t                 in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pbba_pkg::rsp_t                 out_rsp_o,
  input  logic                           cfg_we_i,
  input  logic [pbba_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pbba_pkg::CfgDataW-1:0]  cfg_data_i
);
  import pbba_pkg::*;
  `include "pooled_block_bitmap_allocator_unit_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_FREE   = 4'b0100,
    S_FIN    = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  req_t              req_q;
  logic [NBlkW-1:0]  nblk_q;
  logic [BsW-1:0]    bs_q;
  logic [CountW-1:0] count_q, count_d;
  rsp_t              res_q, res_d;
  logic              out_valid_q;
  rsp_t              out_q, out_d;

  cell_cmd_t         cmd;
  cell_data_t        data_w [MaxPools];
  cell_stat_t        stat_w [MaxPools];
  logic [MaxPools:0] tok_w;
  logic [MaxPools:0] rm_w;
  logic [MaxPools-1:0] open_we, tok_vec, valid_vec, live;

  logic              accept, start, out_load, open_go;
  logic              hit_any, miss_any, zone_any, bit_any, rel_any, slot_found;
  logic [SlotW-1:0]  grant_slot, free_slot;
  logic [BlkW-1:0]   grant_blk;
  logic [NBlkW-1:0]  nblk_eff;
  logic [BsW-1:0]    bs_eff;

  assign in_stall_o = state_q != S_IDLE;
  assign accept     = in_valid_i & ~in_stall_o;
  assign start      = accept & (in_req_i.operation == OP_ALLOC);
  assign out_load   = (state_q == S_FIN) & (~out_valid_q | ~out_stall_i);

  assign nblk_eff = (nblk_q == '0) ? NBlkW'(1)
                  : (nblk_q > NBlkW'(BlocksPerPool)) ? NBlkW'(BlocksPerPool) : nblk_q;
  assign bs_eff   = (bs_q > BsW'(MaxBlockSize)) ? BsW'(MaxBlockSize) : bs_q;

  assign tok_w[0] = start;
  assign rm_w[0]  = 1'b0;

  always_comb begin
    cmd.free_en     = state_q == S_FREE;
    cmd.free_pool   = req_q.free_pool;
    cmd.free_block  = req_q.free_block;
    cmd.open_slot   = free_slot;
    cmd.open_blocks = nblk_eff;
  end

  for (genvar g = 0; g < MaxPools; g++) begin : g_cell
    cell_data_t nxt;
    if (g == MaxPools - 1) begin : g_tail
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = data_w[g+1];
    end
    assign open_we[g] = open_go & (count_q == CountW'(g));

    pbba_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .open_i (open_we[g]),
      .tok_i  (tok_w[g]),
      .rm_i   (rm_w[g]),
      .next_i (nxt),
      .tok_o  (tok_w[g+1]),
      .rm_o   (rm_w[g+1]),
      .data_o (data_w[g]),
      .stat_o (stat_w[g])
    );
  end

  always_comb begin
    hit_any    = 1'b0;
    miss_any   = tok_w[MaxPools];
    zone_any   = 1'b0;
    bit_any    = 1'b0;
    rel_any    = 1'b0;
    grant_slot = '0;
    grant_blk  = '0;
    live       = '0;
    for (int i = 0; i < MaxPools; i++) begin
      hit_any    = hit_any | stat_w[i].hit;
      miss_any   = miss_any | stat_w[i].miss;
      zone_any   = zone_any | stat_w[i].zone_ok;
      bit_any    = bit_any | stat_w[i].bit_set;
      rel_any    = rel_any | stat_w[i].released;
      grant_slot = grant_slot | stat_w[i].grant_slot;
      grant_blk  = grant_blk | stat_w[i].grant_blk;
      if (data_w[i].valid) begin
        live[data_w[i].slot] = 1'b1;
      end
      tok_vec[i]   = stat_w[i].tok;
      valid_vec[i] = data_w[i].valid;
    end
    slot_found = ~&live;
    free_slot  = '0;
    for (int i = MaxPools - 1; i >= 0; i--) begin
      if (!live[i]) begin
        free_slot = SlotW'(i);
      end
    end
  end

  assign open_go = (state_q == S_SEARCH) & miss_any & slot_found;

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    count_d = count_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (in_req_i.operation == OP_ALLOC) ? S_SEARCH : S_FREE;
        end
      end
      S_SEARCH: begin
        if (hit_any || miss_any) begin
          res_d   = '0;
          state_d = S_FIN;
          if (hit_any) begin
            res_d.status        = ST_OK;
            res_d.granted_pool  = grant_slot;
            res_d.granted_block = grant_blk;
          end else if (slot_found) begin
            res_d.status       = ST_OK;
            res_d.granted_pool = free_slot;
            res_d.pool_opened  = 1'b1;
            count_d            = count_q + CountW'(1);
          end else begin
            res_d.status = ST_NO_SPACE;
          end
        end
      end
      S_FREE: begin
        res_d   = '0;
        state_d = S_FIN;
        if (!zone_any) begin
          res_d.status = ST_NOT_IN_ZONE;
        end else if (!bit_any) begin
          res_d.status = ST_DOUBLE_FREE;
        end else begin
          res_d.status        = ST_OK;
          res_d.pool_released = rel_any;
          if (rel_any) begin
            count_d = count_q - CountW'(1);
          end
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d             = res_q;
    out_d.byte_offset = OffW'(res_q.granted_block) * OffW'(bs_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      nblk_q      <= NBlkW'(BlocksPerPool);
      bs_q        <= BsW'(16);
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_BLOCKS_PER_POOL: nblk_q <= cfg_data_i[NBlkW-1:0];
          REG_BLOCK_SIZE:      bs_q   <= cfg_data_i[BsW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    res_q <= res_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `PBBA_ASSERT(a_tok_single, $onehot0(tok_vec), "more than one search token")
  `PBBA_ASSERT(a_count_cells, $countones(valid_vec) == count_q, "pool count off")
  `PBBA_ASSERT_IMP(a_tok_search, state_q != S_SEARCH, tok_vec == '0, "token outside search")
  `PBBA_ASSERT_IMP(a_hit_miss, hit_any, !miss_any, "hit and miss together")

endmodule

`default_nettype wire

// File: hw/rtl/pbba_cell.sv
`default_nettype none

module pbba_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pbba_pkg::cell_cmd_t  cmd_i,
  input  logic                 open_i,
  input  logic                 tok_i,
  input  logic                 rm_i,
  input  pbba_pkg::cell_data_t next_i,
  output logic                 tok_o,
  output logic                 rm_o,
  output pbba_pkg::cell_data_t data_o,
  output pbba_pkg::cell_stat_t stat_o
);
  import pbba_pkg::*;

  logic                     valid_q, valid_d;
  logic [SlotW-1:0]         slot_q, slot_d;
  logic [NBlkW-1:0]         blocks_q, blocks_d;
  logic [BlocksPerPool-1:0] map_q, map_d;
  logic                     tok_q;

  logic [BlocksPerPool-1:0] range_mask, free_bits, iso, fbit, map_clr;
  logic [BlkW-1:0]          low_blk;
  logic                     has_free, hit, match, zone_ok, bit_set, clr, released, shift;

  always_comb begin
    for (int b = 0; b < BlocksPerPool; b++) begin
      range_mask[b] = NBlkW'(b) < blocks_q;
    end
    free_bits = ~map_q & range_mask;
    has_free  = |free_bits;
    iso       = free_bits & (~free_bits + BlocksPerPool'(1));
    low_blk   = '0;
    for (int b = 0; b < BlocksPerPool; b++) begin
      low_blk = low_blk | (iso[b] ? BlkW'(b) : '0);
    end
  end

  assign hit   = tok_q & valid_q & has_free;
  assign tok_o = tok_q & valid_q & ~has_free;

  always_comb begin
    fbit     = BlocksPerPool'(1) << cmd_i.free_block;
    match    = valid_q & (slot_q == cmd_i.free_pool);
    zone_ok  = match & ({1'b0, cmd_i.free_block} < blocks_q);
    bit_set  = |(map_q & fbit);
    map_clr  = map_q & ~fbit;
    clr      = cmd_i.free_en & zone_ok & bit_set;
    released = clr & (map_clr == '0);
  end

  assign shift = rm_i | released;
  assign rm_o  = shift;

  always_comb begin
    valid_d  = valid_q;
    slot_d   = slot_q;
    blocks_d = blocks_q;
    map_d    = map_q;
    if (open_i) begin
      valid_d  = 1'b1;
      slot_d   = cmd_i.open_slot;
      blocks_d = cmd_i.open_blocks;
      map_d    = BlocksPerPool'(1);
    end else if (shift) begin
      valid_d  = next_i.valid;
      slot_d   = next_i.slot;
      blocks_d = next_i.blocks;
      map_d    = next_i.map;
    end else if (hit) begin
      map_d = map_q | iso;
    end else if (clr) begin
      map_d = map_clr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    blocks_q <= blocks_d;
    map_q    <= map_d;
  end

  always_comb begin
    data_o.valid  = valid_q;
    data_o.slot   = slot_q;
    data_o.blocks = blocks_q;
    data_o.map    = map_q;

    stat_o.tok        = tok_q;
    stat_o.hit        = hit;
    stat_o.miss       = tok_q & ~valid_q;
    stat_o.grant_slot = hit ? slot_q : '0;
    stat_o.grant_blk  = hit ? low_blk : '0;
    stat_o.zone_ok    = zone_ok;
    stat_o.bit_set    = zone_ok & bit_set;
    stat_o.released   = released;
  end

endmodule

`default_nettype wire
